// ----- rtl/core/edh_pkg.sv -----
// shared types and constants for the error diffusion halftone block
// no dependencies; imported by edh_regs, edh_chan and the top level
`default_nettype none

package edh_pkg;

    // reset values of the configuration registers
    localparam logic [7:0]  THRESHOLD_RESET = 8'd125;
    localparam logic [11:0] WIDTH_RESET     = 12'd640;

    // default line buffer depth
    localparam int MAX_WIDTH_DEFAULT = 2048;

    // number of color channels and error word width
    localparam int NUM_CHAN = 3;
    localparam int ERR_W    = 9;
    localparam int LINE_W   = NUM_CHAN * ERR_W;

    // register indexes, selected by paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WIDTH     = 1'b1;

    typedef logic signed [ERR_W-1:0] err_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [7:0]  threshold;
        logic [11:0] image_width;
    } cfg_t;

    // per-channel results of one pixel
    typedef struct packed {
        logic on;
        err_t r7;
        err_t bl_sum;
        err_t b_sum;
        err_t br1;
    } chan_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/edh_ram.sv -----
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module edh_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/edh_regs.sv -----
// apb configuration registers: threshold and image width
// depends on edh_pkg
`default_nettype none

module edh_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output edh_pkg::cfg_t     cfg
);
    import edh_pkg::*;

    logic [7:0]  threshold_reg;
    logic [11:0] width_reg;
    logic        wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            width_reg     <= WIDTH_RESET;
        end
        else if (wr_fire)
        begin
            case (paddr[2])
                REG_THRESHOLD: threshold_reg <= pwdata[7:0];
                REG_WIDTH:     width_reg     <= pwdata[11:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_THRESHOLD: prdata = {24'd0, threshold_reg};
            REG_WIDTH:     prdata = {20'd0, width_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.threshold   = threshold_reg;
    assign cfg.image_width = width_reg;

endmodule

`default_nettype wire

// ----- rtl/core/edh_chan.sv -----
// one color channel: error correction, threshold and share split
// depends on edh_pkg
`default_nettype none

module edh_chan (
    input  wire logic [7:0]       sample,
    input  wire logic [7:0]       threshold,
    input  wire edh_pkg::err_t    right_err,
    input  wire edh_pkg::err_t    line_err,
    input  wire logic             use_line,
    input  wire edh_pkg::err_t    bl_pend,
    input  wire edh_pkg::err_t    b_pend,
    output edh_pkg::chan_res_t    res
);
    import edh_pkg::*;

    // (|e| * k) / 16 with the sign of e put back
    function automatic err_t share16(input err_t e, input logic [7:0] mag,
                                     input logic [2:0] k);
        logic [10:0] prod;
        err_t        s;
        prod = 11'(mag) * 11'(k);
        s    = err_t'({2'b00, prod[10:4]});
        return (e < 0) ? -s : s;
    endfunction

    logic signed [10:0] sum;
    logic [7:0]         corr;
    err_t               err;
    logic [7:0]         mag;
    err_t               bl3;
    err_t               b5;

    always_comb
    begin
        sum = $signed({3'b000, sample}) + 11'(right_err)
            + (use_line ? 11'(line_err) : 11'sd0);
        if (sum < 0)
        begin
            corr = 8'd0;
        end
        else if (sum > 11'sd255)
        begin
            corr = 8'd255;
        end
        else
        begin
            corr = sum[7:0];
        end

        res.on = (corr >= threshold);
        err    = res.on ? ($signed({1'b0, corr}) - 9'sd255) : $signed({1'b0, corr});
        mag    = (err < 0) ? 8'(-err) : err[7:0];

        res.r7     = share16(err, mag, 3'd7);
        bl3        = share16(err, mag, 3'd3);
        b5         = share16(err, mag, 3'd5);
        res.br1    = share16(err, mag, 3'd1);
        res.bl_sum = bl_pend + bl3;
        res.b_sum  = b_pend + b5;
    end

endmodule

`default_nettype wire

// ----- rtl/core/error_diffusion_halftone_top.sv -----
// top level of the floyd-steinberg error diffusion halftone block
// depends on edh_pkg, edh_regs, edh_chan and edh_ram
`default_nettype none

// usage
//   s_* carries rgb pixels in raster order; s_tuser[0] marks the first pixel
//   of a new image. m_* carries one transaction per pixel with the on/off
//   bit of red, green and blue. the apb port sets threshold (0x0) and
//   image_width (0x4); write it only while no pixel is in flight.
// throughput
//   one pixel per clock while not stalled. the next-row errors live in a line ram
//   with one write and one registered read port; each pixel reads its column
//   when accepted and writes column-1 as it leaves stage 1. the last pixel of a
//   row has a second write (its own column) that is parked and written in
//   the following free cycle. same-cycle read/write hits are forwarded.
// pipeline
//   an input transaction passes the stage 1 registers, which take the ram read,
//   and the output register. right_reg carries the right-error feedback.
// reset
//   control state and the diffusion registers clear; the line ram has no
//   clearing pass, since the first row of each image does not use its data.
// stall
//   when the output register is full and m_tready is low the whole pipeline
//   holds, s_tready drops and no ram access happens until it drains.
module error_diffusion_halftone_top #(
    parameter int MAX_WIDTH = edh_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  wire logic [0:0]  s_tuser,   // frame_start[0]
    // halftone output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // red_on[0], green_on[1], blue_on[2], zero[7:3]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import edh_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > 12) ? CW + 1 : 12;

    cfg_t cfg;

    edh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline advance: output register empty or being drained
    logic adv;
    logic acc;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;

    // ---------------- stage 0: position and ram read ----------------
    logic [CMPW-1:0] width_ext;
    logic [CMPW-1:0] width_clamp;
    logic [CW-1:0]   last_col;
    logic [CW-1:0]   col;
    logic            last;
    logic            first_row_eff;
    logic [CW-1:0]   column_count_reg;
    logic [CW-1:0]   column_count_next;
    logic            first_row_reg;
    logic            first_row_next;

    always_comb
    begin
        width_ext = CMPW'(cfg.image_width);
        if (width_ext < CMPW'(2))
        begin
            width_clamp = CMPW'(2);
        end
        else if (width_ext > CMPW'(MAX_WIDTH))
        begin
            width_clamp = CMPW'(MAX_WIDTH);
        end
        else
        begin
            width_clamp = width_ext;
        end
        last_col = CW'(width_clamp - CMPW'(1));

        // frame start restarts the position before this pixel
        if (s_tuser[0])
        begin
            col           = '0;
            first_row_eff = 1'b1;
        end
        else
        begin
            col           = column_count_reg;
            first_row_eff = first_row_reg;
        end

        // a column at or past the row end counts as the last one
        if (col >= last_col)
        begin
            col  = last_col;
            last = 1'b1;
        end
        else
        begin
            last = 1'b0;
        end

        column_count_next = last ? '0 : CW'(col + CW'(1));
        first_row_next    = last ? 1'b0 : first_row_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            first_row_reg    <= 1'b1;
        end
        else if (acc)
        begin
            column_count_reg <= column_count_next;
            first_row_reg    <= first_row_next;
        end
    end

    // ---------------- line ram and its write arbitration ----------------
    logic              ram_we;
    logic [CW-1:0]     ram_waddr;
    logic [LINE_W-1:0] ram_wdata;
    logic [LINE_W-1:0] ram_rdata;

    edh_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (acc),
        .rd_addr (col),
        .rd_data (ram_rdata)
    );

    // stage 1 registers
    logic              s1_valid_reg;
    logic              s1_fs_reg;
    logic              s1_last_reg;
    logic              s1_use_line_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [23:0]       s1_pix_reg;
    logic              byp_hit_reg;
    logic [LINE_W-1:0] byp_data_reg;

    // diffusion state
    err_t right_reg [NUM_CHAN];
    err_t bl_pend_reg [NUM_CHAN];
    err_t b_pend_reg [NUM_CHAN];

    // parked write of the last column of a row
    logic              tail_valid_reg;
    logic [CW-1:0]     tail_addr_reg;
    logic [LINE_W-1:0] tail_data_reg;

    logic              s1_commit;
    logic              s1_we;
    logic              tail_we;
    logic [LINE_W-1:0] bl_word;
    logic [LINE_W-1:0] b_word;
    logic [LINE_W-1:0] line_word;
    logic [NUM_CHAN-1:0] on_bits;
    logic              byp_hit_next;

    assign s1_commit = adv && s1_valid_reg;
    assign s1_we     = s1_commit && (s1_col_reg != '0);
    assign tail_we   = adv && tail_valid_reg && !s1_we;
    assign ram_we    = s1_we || tail_we;
    assign ram_waddr = s1_we ? CW'(s1_col_reg - CW'(1)) : tail_addr_reg;
    assign ram_wdata = s1_we ? bl_word : tail_data_reg;

    // a write in the read cycle is not seen by the ram read; forward it
    assign byp_hit_next = acc && ram_we && (ram_waddr == col);
    assign line_word    = byp_hit_reg ? byp_data_reg : ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= acc;
            byp_hit_reg  <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_fs_reg       <= s_tuser[0];
            s1_last_reg     <= last;
            s1_use_line_reg <= !first_row_eff;
            s1_col_reg      <= col;
            s1_pix_reg      <= s_tdata;
            byp_data_reg    <= ram_wdata;
        end
    end

    // ---------------- stage 1: per-channel arithmetic ----------------
    chan_res_t res [NUM_CHAN];

    for (genvar i = 0; i < NUM_CHAN; i++)
    begin : g_chan
        edh_chan u_chan (
            .sample    (s1_pix_reg[8*i +: 8]),
            .threshold (cfg.threshold),
            .right_err (s1_fs_reg ? err_t'(0) : right_reg[i]),
            .line_err  (line_word[ERR_W*i +: ERR_W]),
            .use_line  (s1_use_line_reg),
            .bl_pend   (s1_fs_reg ? err_t'(0) : bl_pend_reg[i]),
            .b_pend    (s1_fs_reg ? err_t'(0) : b_pend_reg[i]),
            .res       (res[i])
        );

        assign bl_word[ERR_W*i +: ERR_W] = res[i].bl_sum;
        assign b_word[ERR_W*i +: ERR_W]  = res[i].b_sum;
        assign on_bits[i]                = res[i].on;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                right_reg[i]   <= '0;
                bl_pend_reg[i] <= '0;
                b_pend_reg[i]  <= '0;
            end
            else if (s1_commit)
            begin
                if (s1_last_reg)
                begin
                    right_reg[i]   <= '0;
                    bl_pend_reg[i] <= '0;
                    b_pend_reg[i]  <= '0;
                end
                else
                begin
                    right_reg[i]   <= res[i].r7;
                    bl_pend_reg[i] <= res[i].b_sum;
                    b_pend_reg[i]  <= res[i].br1;
                end
            end
        end
    end

    // parked last-column write; the next pixel is column 0, which frees the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_valid_reg <= 1'b0;
        end
        else if (s1_commit && s1_last_reg)
        begin
            tail_valid_reg <= 1'b1;
        end
        else if (tail_we)
        begin
            tail_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_commit && s1_last_reg)
        begin
            tail_addr_reg <= s1_col_reg;
            tail_data_reg <= b_word;
        end
    end

    // ---------------- output register ----------------
    logic       m_valid_reg;
    logic [7:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_commit)
        begin
            m_data_reg <= {5'd0, on_bits};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/edh_checker.sv -----
// port-level checks of the error diffusion halftone block, bound to the top
// depends on error_diffusion_halftone_top
`default_nettype none

module edh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [31:0] prdata
);

    // a stalled output transaction holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction changed while stalled");

    // input is taken exactly when the output register can move
    a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output register state");

    // every accepted pixel sets output valid after the stage 1 and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted pixel missing at output");

    // padding bits of results and register reads stay zero
    a_zero_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tdata[7:3] == 5'd0) && prdata[31:12] == 20'd0)
        else $error("nonzero padding bits");

endmodule

bind error_diffusion_halftone_top edh_checker u_edh_checker (.*);

`default_nettype wire
